@@ rtl/adrc_pkg.sv @@
// adrc_pkg: shared types and constants for the audio dynamic range compressor
// controller state, command and status records, register indexes, fixed field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package adrc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int THR_W     = 16;
	localparam int IR_W      = 17;
	localparam int MKP_W     = 16;
	localparam int GAIN_W    = 18;
	localparam int GAIN_FRAC = 16;
	localparam int MKP_FRAC  = 12;
	localparam int LVL_SHIFT = 8;
	localparam int CNT_W     = 5;

	localparam logic [THR_W-1:0]  THR_RST   = 16'd32768;
	localparam logic [IR_W-1:0]   IR_RST    = 17'd65536;
	localparam logic [MKP_W-1:0]  MKP_RST   = 16'd4096;
	localparam logic [GAIN_W-1:0] GAIN_ONE  = 18'd65536;

	// multiplier digit steps (two bits each) and divider steps (one bit each)
	localparam logic [CNT_W-1:0] OVR_STEPS  = 5'd9;
	localparam logic [CNT_W-1:0] GAIN_STEPS = 5'd9;
	localparam logic [CNT_W-1:0] MKP_STEPS  = 5'd8;
	localparam logic [CNT_W-1:0] DIV_STEPS  = 5'd18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_INV_RATIO = 3'd1,
		REG_ATTACK    = 3'd2,
		REG_RELEASE   = 3'd3,
		REG_MAKEUP    = 3'd4,
		REG_ENABLE    = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENV_LD,
		S_ENV_MUL,
		S_ENV_UPD,
		S_OVR_LD,
		S_OVR_MUL,
		S_DIV_LD,
		S_DIV,
		S_GAIN_LD,
		S_GAIN_MUL,
		S_MKP_LD,
		S_MKP_MUL,
		S_RESULT
	} state_t;

	typedef enum logic [1:0] {
		MUL_ENV,
		MUL_OVER,
		MUL_GAIN,
		MUL_MKP
	} mul_op_t;

	typedef struct packed {
		logic    capture;
		logic    mul_load;
		mul_op_t mul_op;
		logic    mul_step;
		logic    env_write;
		logic    div_load;
		logic    div_step;
		logic    gain_unity;
		logic    res_write;
	} cmd_t;

	typedef struct packed {
		logic over_thr;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/adrc_in_if.sv @@
// adrc_in_if: input sample channel, valid/ready with one sample per beat
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface adrc_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ rtl/adrc_out_if.sv @@
// adrc_out_if: result sample channel, valid/ready with one sample per beat
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface adrc_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ rtl/adrc_cfg_if.sv @@
// adrc_cfg_if: register write channel, valid/ready with index and data per beat
// depends on adrc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface adrc_cfg_if #(
	parameter int DATA_W = 17
);
	import adrc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/adrc_ctrl.sv @@
// adrc_ctrl: sequencer for the compressor, steps the datapath through one sample
// owns the output valid flag; depends on adrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module adrc_ctrl #(
	parameter int COEFF_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  wire               enable,
	input  adrc_pkg::status_t status,
	output adrc_pkg::cmd_t    cmd
);
	import adrc_pkg::*;

	localparam logic [CNT_W-1:0] ENV_STEPS = CNT_W'((COEFF_BITS + 1) / 2);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = enable ? S_ENV_LD : S_RESULT;
				end
			end
			S_ENV_LD: begin
				cnt_d   = ENV_STEPS;
				state_d = S_ENV_MUL;
			end
			S_ENV_MUL: begin
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_ENV_UPD;
				end
			end
			S_ENV_UPD: begin
				state_d = S_OVR_LD;
			end
			S_OVR_LD: begin
				if (status.over_thr) begin
					cnt_d   = OVR_STEPS;
					state_d = S_OVR_MUL;
				end else begin
					state_d = S_GAIN_LD;
				end
			end
			S_OVR_MUL: begin
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_DIV_LD;
				end
			end
			S_DIV_LD: begin
				cnt_d   = DIV_STEPS;
				state_d = S_DIV;
			end
			S_DIV: begin
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_GAIN_LD;
				end
			end
			S_GAIN_LD: begin
				cnt_d   = GAIN_STEPS;
				state_d = S_GAIN_MUL;
			end
			S_GAIN_MUL: begin
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_MKP_LD;
				end
			end
			S_MKP_LD: begin
				cnt_d   = MKP_STEPS;
				state_d = S_MKP_MUL;
			end
			S_MKP_MUL: begin
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_ENV_LD: begin
				cmd.mul_load = 1'b1;
				cmd.mul_op   = MUL_ENV;
			end
			S_ENV_UPD: begin
				cmd.env_write = 1'b1;
			end
			S_OVR_LD: begin
				if (status.over_thr) begin
					cmd.mul_load = 1'b1;
					cmd.mul_op   = MUL_OVER;
				end else begin
					cmd.gain_unity = 1'b1;
				end
			end
			S_ENV_MUL, S_OVR_MUL, S_GAIN_MUL, S_MKP_MUL: begin
				cmd.mul_step = 1'b1;
			end
			S_DIV_LD: begin
				cmd.div_load = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_GAIN_LD: begin
				cmd.mul_load = 1'b1;
				cmd.mul_op   = MUL_GAIN;
			end
			S_MKP_LD: begin
				cmd.mul_load = 1'b1;
				cmd.mul_op   = MUL_MKP;
			end
			S_RESULT: begin
				cmd.res_write = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= cmd.res_write || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/adrc_dp.sv @@
// adrc_dp: compressor datapath with envelope register, shared radix-4 multiplier,
// restoring gain divider and output saturation; depends on adrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module adrc_dp #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEFF_BITS  = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  adrc_pkg::cmd_t                      cmd,
	output adrc_pkg::status_t                   status,
	input  wire signed [SAMPLE_BITS-1:0]        sample_in,
	input  wire [adrc_pkg::THR_W-1:0]           threshold_gain,
	input  wire [adrc_pkg::IR_W-1:0]            inverse_ratio,
	input  wire [COEFF_BITS-1:0]                attack_coeff,
	input  wire [COEFF_BITS-1:0]                release_coeff,
	input  wire [adrc_pkg::MKP_W-1:0]           makeup_gain,
	input  wire                                 enable,
	output logic signed [SAMPLE_BITS-1:0]       sample_out
);
	import adrc_pkg::*;

	localparam int ENV_W     = SAMPLE_BITS + LVL_SHIFT;
	localparam int THR_SHIFT = SAMPLE_BITS - LVL_SHIFT;
	localparam int ENV_STEPS = (COEFF_BITS + 1) / 2;
	localparam int BW        = (2 * ENV_STEPS > GAIN_W) ? 2 * ENV_STEPS : GAIN_W;
	localparam int AW        = ENV_W;
	localparam int PW        = AW + BW;
	localparam int M1_W      = SAMPLE_BITS + 2;
	localparam int M2_W      = M1_W + MKP_W - MKP_FRAC;
	localparam int SB        = SAMPLE_BITS;

	localparam logic [PW:0]     ENV_HALF = (PW + 1)'(1) << (COEFF_BITS - 1);
	localparam logic [PW-1:0]   RND_G    = PW'(1) << (GAIN_FRAC - 1);
	localparam logic [PW-1:0]   RND_M    = PW'(1) << (MKP_FRAC - 1);
	localparam logic [M2_W-1:0] SAT_NEG  = M2_W'(1) << (SB - 1);
	localparam logic [M2_W-1:0] SAT_POS  = SAT_NEG - M2_W'(1);

	logic [SB-1:0]     mag_q;
	logic              neg_q;
	logic              byp_q;
	logic [ENV_W-1:0]  env_q;
	logic [AW-1:0]     a_q;
	logic [BW-1:0]     b_q;
	logic [PW-1:0]     acc_q;
	logic [ENV_W-1:0]  rem_q;
	logic [GAIN_W-1:0] dl_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SB-1:0]     sample_out_q;

	logic [SB-1:0]     raw;
	logic [SB-1:0]     mag_d;
	logic [ENV_W-1:0]  level;
	logic [ENV_W-1:0]  thr;
	logic              rise;
	logic [ENV_W-1:0]  delta;
	logic [COEFF_BITS-1:0] coeff;
	logic [AW-1:0]     a_d;
	logic [BW-1:0]     b_d;
	logic [AW+1:0]     pp;
	logic [PW:0]       env_rnd;
	logic [ENV_W-1:0]  env_new;
	logic [PW-1:0]     ovr_rnd;
	logic [ENV_W+1:0]  comp;
	logic [ENV_W:0]    r2;
	logic              ge;
	logic [PW-1:0]     m1_full;
	logic [M1_W-1:0]   m1;
	logic [PW-1:0]     m2_full;
	logic [M2_W-1:0]   mres;
	logic [M2_W-1:0]   satv;
	logic [SB-1:0]     res;

	// sample magnitude and sign
	always_comb begin
		raw   = sample_in;
		mag_d = raw[SB-1] ? (~raw + SB'(1)) : raw;
	end

	// envelope update terms
	always_comb begin
		level   = {mag_q, {LVL_SHIFT{1'b0}}};
		thr     = ENV_W'(threshold_gain) << THR_SHIFT;
		rise    = level > env_q;
		delta   = rise ? (level - env_q) : (env_q - level);
		coeff   = rise ? attack_coeff : release_coeff;
		env_rnd = (PW + 1)'(acc_q) + ENV_HALF;
		if (rise) begin
			env_new = level - ENV_W'((env_rnd - (PW + 1)'(1)) >> COEFF_BITS);
		end else begin
			env_new = level + ENV_W'(env_rnd >> COEFF_BITS);
		end
		status.over_thr = env_q > thr;
	end

	// compressed level and product roundings
	always_comb begin
		ovr_rnd = (acc_q + RND_G) >> GAIN_FRAC;
		comp    = (ENV_W + 2)'(thr) + ovr_rnd[ENV_W+1:0];
		m1_full = (acc_q + RND_G) >> GAIN_FRAC;
		m1      = m1_full[M1_W-1:0];
		m2_full = (acc_q + RND_M) >> MKP_FRAC;
		mres    = byp_q ? M2_W'(mag_q) : m2_full[M2_W-1:0];
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_op)
			MUL_ENV: begin
				a_d = delta;
				b_d = BW'(coeff) << (BW - 2 * ENV_STEPS);
			end
			MUL_OVER: begin
				a_d = env_q - thr;
				b_d = BW'(inverse_ratio) << (BW - 2 * int'(OVR_STEPS));
			end
			MUL_GAIN: begin
				a_d = AW'(mag_q);
				b_d = BW'(gain_q) << (BW - 2 * int'(GAIN_STEPS));
			end
			MUL_MKP: begin
				a_d = AW'(m1);
				b_d = BW'(makeup_gain) << (BW - 2 * int'(MKP_STEPS));
			end
			default: begin
				a_d = '0;
				b_d = '0;
			end
		endcase
	end

	// two multiplier bits per step, msb first
	always_comb begin
		pp = ({2'b00, a_q} & {(AW + 2){b_q[BW-2]}})
			+ ({1'b0, a_q, 1'b0} & {(AW + 2){b_q[BW-1]}});
	end

	// one quotient bit per step
	always_comb begin
		r2 = {rem_q, dl_q[GAIN_W-1]};
		ge = r2 >= {1'b0, env_q};
	end

	// sign and saturation
	always_comb begin
		if (neg_q) begin
			satv = (mres > SAT_NEG) ? SAT_NEG : mres;
			res  = ~satv[SB-1:0] + SB'(1);
		end else begin
			satv = (mres > SAT_POS) ? SAT_POS : mres;
			res  = satv[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (cmd.env_write) begin
			env_q <= env_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mag_q <= mag_d;
			neg_q <= raw[SB-1];
			byp_q <= !enable;
		end
		if (cmd.mul_load) begin
			a_q   <= a_d;
			b_q   <= b_d;
			acc_q <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= (acc_q << 2) + PW'(pp);
			b_q   <= b_q << 2;
		end
		if (cmd.div_load) begin
			rem_q <= comp[ENV_W+1:2];
			dl_q  <= {comp[1:0], {GAIN_FRAC{1'b0}}};
		end else if (cmd.div_step) begin
			rem_q <= ge ? ENV_W'(r2 - {1'b0, env_q}) : ENV_W'(r2);
			dl_q  <= dl_q << 1;
		end
		if (cmd.gain_unity) begin
			gain_q <= GAIN_ONE;
		end else if (cmd.div_step) begin
			gain_q <= {gain_q[GAIN_W-2:0], ge};
		end
		if (cmd.res_write) begin
			sample_out_q <= res;
		end
	end

	assign sample_out = sample_out_q;

endmodule

`default_nettype wire

@@ rtl/audio_dynamic_range_compressor.sv @@
// audio_dynamic_range_compressor: top level with register file, sequencer and datapath
// depends on adrc_pkg, adrc_in_if, adrc_out_if, adrc_cfg_if, adrc_ctrl, adrc_dp
`timescale 1ns / 1ps
`default_nettype none

// Feed-forward peak compressor on signed samples, one result beat per input beat.
// A sample is processed on its own from acceptance to result: with the envelope
// above threshold the over-threshold product and the gain division are run, at or
// below threshold the gain is unity, and when disabled the sample bypasses envelope
// and gain. The shared multiplier retires two operand bits per cycle over up to four
// products, and the gain divider retires one quotient bit per cycle over 18 bits.
// A finished result waits in the output register while the
// next sample is taken in. Registers are written on the cfg channel, which is
// always ready; its data width must be at least max(17, COEFF_BITS). Writes are
// expected only while no sample is in flight.
module audio_dynamic_range_compressor #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEFF_BITS  = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	adrc_in_if.sink      sample_ch,
	adrc_out_if.source   result_ch,
	adrc_cfg_if.sink     cfg
);
	import adrc_pkg::*;

	logic [THR_W-1:0]      thr_q;
	logic [IR_W-1:0]       ir_q;
	logic [COEFF_BITS-1:0] att_q;
	logic [COEFF_BITS-1:0] rel_q;
	logic [MKP_W-1:0]      mkp_q;
	logic                  en_q;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RST;
			ir_q  <= IR_RST;
			att_q <= '0;
			rel_q <= '0;
			mkp_q <= MKP_RST;
			en_q  <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_THRESHOLD: thr_q <= cfg.wdata[THR_W-1:0];
				REG_INV_RATIO: ir_q  <= cfg.wdata[IR_W-1:0];
				REG_ATTACK:    att_q <= cfg.wdata[COEFF_BITS-1:0];
				REG_RELEASE:   rel_q <= cfg.wdata[COEFF_BITS-1:0];
				REG_MAKEUP:    mkp_q <= cfg.wdata[MKP_W-1:0];
				REG_ENABLE:    en_q  <= cfg.wdata[0];
				default: begin
				end
			endcase
		end
	end

	adrc_ctrl #(
		.COEFF_BITS(COEFF_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.enable    (en_q),
		.status    (status),
		.cmd       (cmd)
	);

	adrc_dp #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEFF_BITS (COEFF_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.sample_in      (sample_ch.sample_in),
		.threshold_gain (thr_q),
		.inverse_ratio  (ir_q),
		.attack_coeff   (att_q),
		.release_coeff  (rel_q),
		.makeup_gain    (mkp_q),
		.enable         (en_q),
		.sample_out     (result_ch.sample_out)
	);

	// a taken beat closes the input right after its capture
	a_busy_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !sample_ch.ready)
		else $error("input reopened right after capture");

	// a pending result is never overwritten
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_write |-> (!result_ch.valid || result_ch.ready))
		else $error("result written over a pending beat");

	// datapath commands are exclusive
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.mul_load, cmd.mul_step, cmd.env_write,
			cmd.div_load, cmd.div_step, cmd.gain_unity, cmd.res_write}))
		else $error("overlapping datapath commands");

	// envelope is written only from a finished product
	a_env_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.env_write |-> $past(cmd.mul_step))
		else $error("envelope written without a finished product");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking testbench for audio_dynamic_range_compressor
// drives samples and register writes, predicts each output sample and compares it
// depends on adrc_pkg, adrc_in_if, adrc_out_if, adrc_cfg_if and the rtl top level
`timescale 1ns / 1ps

module tb;
	import adrc_pkg::*;

	typedef struct {
		logic [15:0] smp;
		int          gap;
	} feed_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [15:0] in_data   = '0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	cfg_reg_t    cfg_idx   = REG_THRESHOLD;
	logic [16:0] cfg_data  = '0;

	// register and envelope copies for the predictor
	logic [15:0] thr_cfg = THR_RST;
	logic [16:0] ir_cfg  = IR_RST;
	logic [15:0] atk_cfg = '0;
	logic [15:0] rel_cfg = '0;
	logic [15:0] mkp_cfg = MKP_RST;
	logic        en_cfg  = 1'b1;
	logic [23:0] env_lvl = '0;

	feed_t       sample_feed[$];
	logic [15:0] compressed_q[$];
	feed_t       head;
	logic [15:0] want;
	int          in_gap_max    = 0;
	int          out_stall_max = 0;
	int          stall_left    = 0;
	int          n_added       = 0;
	int          n_sent        = 0;
	int          n_checked     = 0;
	int          n_writes      = 0;
	int          n_errors      = 0;

	adrc_in_if #(.SAMPLE_BITS(16)) smp_if ();
	adrc_out_if #(.SAMPLE_BITS(16)) res_if ();
	adrc_cfg_if #(.DATA_W(17)) cfg_if ();

	assign smp_if.valid     = in_valid;
	assign smp_if.sample_in = in_data;
	assign res_if.ready     = out_ready;
	assign cfg_if.valid     = cfg_valid;
	assign cfg_if.index     = cfg_idx;
	assign cfg_if.wdata     = cfg_data;

	audio_dynamic_range_compressor #(
		.SAMPLE_BITS(16),
		.COEFF_BITS (16)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(smp_if),
		.result_ch(res_if),
		.cfg      (cfg_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= 40)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic logic [15:0] compress_sample(input logic [15:0] x);
		logic        neg;
		logic [15:0] neg_x;
		logic [63:0] mag, lvl, c, env, thr, gain, m, over, comp;
		neg   = x[15];
		neg_x = -x;
		mag   = {48'd0, neg ? neg_x : x};
		if (!en_cfg)
			return x;
		lvl = mag << 8;
		env = {40'd0, env_lvl};
		c   = (lvl > env) ? {48'd0, atk_cfg} : {48'd0, rel_cfg};
		env = (lvl * (64'd65536 - c) + env * c + 64'd32768) >> 16;
		env = env & 64'hFF_FFFF;
		env_lvl = env[23:0];
		thr  = {40'd0, thr_cfg, 8'd0};
		gain = 64'd65536;
		if (env > thr) begin
			over = env - thr;
			comp = thr + ((over * {47'd0, ir_cfg} + 64'd32768) >> 16);
			gain = (comp << 16) / env;
		end
		m = (mag * gain + 64'd32768) >> 16;
		m = (m * {48'd0, mkp_cfg} + 64'd2048) >> 12;
		if (neg) begin
			if (m > 64'd32768)
				m = 64'd32768;
			return ~m[15:0] + 16'd1;
		end
		if (m > 64'd32767)
			m = 64'd32767;
		return m[15:0];
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && smp_if.ready) begin
				compressed_q.push_back(compress_sample(in_data));
				n_sent++;
			end
			if (!in_valid || smp_if.ready) begin
				if (sample_feed.size() == 0) begin
					in_valid <= 1'b0;
				end else if (sample_feed[0].gap != 0) begin
					sample_feed[0].gap = sample_feed[0].gap - 1;
					in_valid <= 1'b0;
				end else begin
					head = sample_feed.pop_front();
					in_valid <= 1'b1;
					in_data  <= head.smp;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (res_if.valid && out_ready) begin
			if (compressed_q.size() == 0) begin
				report($sformatf("result beat %0d with nothing expected",
					$signed(res_if.sample_out)));
			end else begin
				want = compressed_q.pop_front();
				if (res_if.sample_out !== want)
					report($sformatf("sample_out %0d, expected %0d",
						$signed(res_if.sample_out), $signed(want)));
			end
			n_checked++;
			stall_left <= (out_stall_max > 0) ? $urandom_range(0, out_stall_max) : 0;
			out_ready  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [16:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_idx   <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			REG_THRESHOLD: thr_cfg = val[15:0];
			REG_INV_RATIO: ir_cfg  = val;
			REG_ATTACK:    atk_cfg = val[15:0];
			REG_RELEASE:   rel_cfg = val[15:0];
			REG_MAKEUP:    mkp_cfg = val[15:0];
			REG_ENABLE:    en_cfg  = val[0];
			default: ;
		endcase
		n_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_sample(input logic [15:0] s);
		feed_t f;
		f.smp = s;
		f.gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
		sample_feed.push_back(f);
		n_added++;
	endtask

	// wait until every queued sample has come back as a result beat
	task automatic drain();
		while (n_checked < n_added)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] draw_sample(input int amp);
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 2 * amp - 1) - amp);
		endcase
	endfunction

	task automatic random_setup();
		logic [16:0] v;
		case ($urandom_range(0, 3))
			0: v = 17'd0;
			1: v = 17'd32768;
			2: v = 17'd65535;
			default: v = 17'($urandom_range(0, 32768));
		endcase
		write_reg(REG_THRESHOLD, v);
		case ($urandom_range(0, 4))
			0: v = 17'd0;
			1: v = 17'd65536;
			2: v = 17'd131071;
			3: v = 17'($urandom_range(65537, 131071));
			default: v = 17'($urandom_range(0, 65536));
		endcase
		write_reg(REG_INV_RATIO, v);
		case ($urandom_range(0, 2))
			0: v = 17'd0;
			1: v = 17'd65535;
			default: v = 17'($urandom_range(0, 65535));
		endcase
		write_reg(REG_ATTACK, v);
		case ($urandom_range(0, 2))
			0: v = 17'd0;
			1: v = 17'd65535;
			default: v = 17'($urandom_range(0, 65535));
		endcase
		write_reg(REG_RELEASE, v);
		case ($urandom_range(0, 4))
			0: v = 17'd0;
			1: v = 17'd4096;
			2: v = 17'd65535;
			3: v = 17'($urandom_range(0, 65535));
			default: v = 17'($urandom_range(2048, 8192));
		endcase
		write_reg(REG_MAKEUP, v);
		write_reg(REG_ENABLE, ($urandom_range(0, 5) == 0) ? 17'd0 : 17'd1);
	endtask

	initial begin
		int amp;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: unity gain, envelope tracks instantly
		in_gap_max    = 3;
		out_stall_max = 3;
		add_sample(16'h7FFF);
		add_sample(16'h8000);
		add_sample(16'h0000);
		add_sample(16'hFFFF);
		add_sample(16'h0001);
		drain();

		// low threshold, 4:1 ratio, slow release
		write_reg(REG_THRESHOLD, 17'd4096);
		write_reg(REG_INV_RATIO, 17'd16384);
		write_reg(REG_ATTACK, 17'd0);
		write_reg(REG_RELEASE, 17'd65535);
		write_reg(REG_MAKEUP, 17'd4096);
		write_reg(REG_ENABLE, 17'd1);
		add_sample(16'h8000);
		add_sample(16'h7FFF);
		add_sample(16'd12000);
		add_sample(-16'sd20000);
		add_sample(16'h0000);
		drain();

		// expansion with full makeup, output saturates
		write_reg(REG_INV_RATIO, 17'd131071);
		write_reg(REG_MAKEUP, 17'd65535);
		add_sample(16'h7FFF);
		add_sample(16'h8000);
		add_sample(16'd3000);
		add_sample(-16'sd3000);
		drain();

		// zero makeup silences the output
		write_reg(REG_MAKEUP, 17'd0);
		add_sample(16'd20000);
		add_sample(-16'sd20000);
		drain();

		// threshold above full scale keeps unity gain
		write_reg(REG_MAKEUP, 17'd4096);
		write_reg(REG_THRESHOLD, 17'd65535);
		add_sample(16'h7FFF);
		add_sample(16'h8000);
		drain();

		// bypass, envelope holds
		write_reg(REG_ENABLE, 17'd0);
		add_sample(16'h5555);
		add_sample(16'hAAAA);
		add_sample(16'h8000);
		add_sample(16'h7FFF);
		drain();

		// zero threshold and zero ratio give zero gain
		write_reg(REG_ENABLE, 17'd1);
		write_reg(REG_THRESHOLD, 17'd0);
		write_reg(REG_INV_RATIO, 17'd0);
		add_sample(16'd100);
		add_sample(16'hFFFF);
		drain();

		for (int p = 0; p < 10; p++) begin
			random_setup();
			in_gap_max    = (p % 3 == 1) ? 0 : 6;
			out_stall_max = (p % 4 == 2) ? 0 : 6;
			amp = 512;
			for (int i = 0; i < 40; i++) begin
				if (i % 8 == 0) begin
					case ($urandom_range(0, 2))
						0: amp = 512;
						1: amp = 4096;
						default: amp = 32768;
					endcase
				end
				add_sample(draw_sample(amp));
			end
			drain();
		end

		repeat (70) @(posedge clk);
		while (compressed_q.size() != 0) begin
			want = compressed_q.pop_front();
			report($sformatf("expected sample %0d never arrived", $signed(want)));
		end
		$display("covered %0d samples over 17 register settings with %0d register writes",
			n_sent, n_writes);
		$display("%0d output beats checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#1000000;
		$display("timeout: %0d samples still queued, %0d results outstanding",
			sample_feed.size(), compressed_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
